// ===== sv/blt_pkg.sv =====
// Shared types, constants and glyph maps of the bitmap text layout block.
package blt_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_GLYPHS_DEF = 128;
    localparam int TAB_CELLS_DEF  = 10;

    // Port widths of the streaming and configuration interfaces.
    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SELECT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MONOSPACE_ALIGN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_H_SPACING       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_V_SPACING       = 3'd4;

    // Command codes carried in tuser.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_CHAR  = 2'd2;

    // Character codes with a control meaning.
    localparam logic [7:0] CODE_TILDE       = 8'h7E;
    localparam logic [7:0] CODE_NEWLINE     = 8'h0A;
    localparam logic [7:0] CODE_NEWLINE_ALT = 8'hB3;
    localparam logic [7:0] CODE_TAB         = 8'hA9;

    // Map entry for a code without a glyph.
    localparam logic [7:0] NG = 8'd255;

    // Operation kinds handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_START,
        OP_TILDE,
        OP_NEWLINE,
        OP_TAB,
        OP_SPACE,
        OP_GLYPH
    } t_op_kind;

    // One classified item waiting in the queue.
    typedef struct packed {
        t_op_kind    kind;
        logic [6:0]  slot;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [7:0]  color_a;
        logic [7:0]  color_b;
        logic [6:0]  glyph;
    } t_op;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] glyph_count;
        logic       table_select;
        logic       monospace_align;
        logic [7:0] h_spacing;
        logic [7:0] v_spacing;
    } t_cfg;

    // Map with letters folded to one case.
    localparam logic [7:0] MAP_FOLDED [256] = '{
        NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,
        NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,
        NG,8'd36,NG,8'd53,8'd51,8'd45,NG,8'd47,8'd41,8'd42,8'd49,8'd43,8'd51,8'd44,8'd38,8'd40,
        8'd26,8'd27,8'd28,8'd29,8'd30,8'd31,8'd32,8'd33,8'd34,8'd35,8'd39,NG,NG,8'd46,NG,8'd37,
        8'd52,8'd0,8'd1,8'd2,8'd3,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,8'd14,
        8'd15,8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,NG,8'd50,NG,NG,8'd48,
        NG,8'd0,8'd1,8'd2,8'd3,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,8'd14,
        8'd15,8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,NG,NG,NG,NG,NG,
        NG,NG,8'd4,NG,NG,8'd0,NG,NG,8'd0,NG,8'd4,NG,NG,NG,8'd4,NG,
        NG,NG,NG,8'd14,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,
        NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,
        NG,NG,NG,NG,NG,NG,NG,NG,8'd4,NG,NG,NG,NG,NG,NG,NG,
        NG,NG,NG,NG,8'd0,NG,NG,NG,NG,NG,NG,8'd4,NG,8'd8,NG,8'd8,
        NG,8'd13,NG,8'd14,NG,NG,8'd14,NG,NG,NG,NG,NG,8'd20,NG,NG,NG,
        NG,NG,NG,NG,8'd0,NG,NG,NG,NG,8'd4,NG,NG,NG,NG,NG,NG,
        NG,NG,NG,8'd14,NG,NG,8'd14,NG,NG,NG,NG,NG,8'd20,NG,NG,NG
    };

    // Map with the full printable set.
    localparam logic [7:0] MAP_FULL [256] = '{
        NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,
        NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,
        NG,8'd0,8'd1,8'd2,8'd3,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,8'd14,
        8'd15,8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,8'd26,8'd27,8'd28,8'd29,8'd30,
        8'd31,8'd32,8'd33,8'd34,8'd35,8'd36,8'd37,8'd38,8'd39,8'd40,8'd41,8'd42,8'd43,8'd44,8'd45,8'd46,
        8'd47,8'd48,8'd49,8'd50,8'd51,8'd52,8'd53,8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,
        8'd63,8'd64,8'd65,8'd66,8'd67,8'd68,8'd69,8'd70,8'd71,8'd72,8'd73,8'd74,8'd75,8'd76,8'd77,8'd78,
        8'd79,8'd80,8'd81,8'd82,8'd83,8'd84,8'd85,8'd86,8'd87,8'd88,8'd89,8'd90,8'd91,8'd92,8'd93,8'd94,
        NG,NG,8'd68,NG,NG,8'd64,NG,NG,8'd64,NG,8'd68,NG,NG,NG,8'd68,NG,
        NG,NG,NG,8'd78,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,
        NG,8'd0,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,
        NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,NG,8'd30,
        NG,NG,NG,NG,8'd64,NG,NG,NG,NG,NG,NG,8'd68,NG,8'd72,NG,8'd72,
        NG,8'd77,NG,8'd78,NG,NG,8'd78,NG,NG,NG,NG,NG,8'd84,NG,NG,NG,
        NG,NG,NG,NG,8'd64,NG,NG,NG,NG,8'd68,NG,NG,NG,NG,NG,NG,
        NG,NG,NG,8'd78,NG,NG,8'd78,NG,NG,NG,NG,NG,8'd84,NG,NG,NG
    };

    // Glyph number of a character code in the selected map.
    function automatic logic [7:0] glyph_map(input logic sel, input logic [7:0] code);
        glyph_map = sel ? MAP_FULL[code] : MAP_FOLDED[code];
    endfunction

endpackage

// ===== sv/blt_ram.sv =====
// Generic single-port-write, registered-read RAM.
module blt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/blt_front.sv =====
// Front end: accepts input items, classifies them and queues the operations.
module blt_front #(
    parameter int MAX_GLYPHS = blt_pkg::MAX_GLYPHS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  blt_pkg::t_cfg                   i_cfg,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata from bit 0: glyph_slot, glyph_width, glyph_height, start_x, start_y,
    // color_a, color_b, char_code, one zero pad bit
    input  logic [blt_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser: command
    input  logic [blt_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                            o_op_valid,
    output blt_pkg::t_op                    o_op,
    input  logic                            i_op_pop
);

    import blt_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);

    logic [7:0]     code;
    logic [7:0]     glyph8;
    logic           no_glyph;
    t_op            n_op;
    logic           push;
    t_op            r_q [QDEPTH];
    logic [QPW-1:0] r_wptr;
    logic [QPW-1:0] r_rptr;
    logic [QPW:0]   r_cnt;

    assign code   = i_s_axis_tdata[78:71];
    assign glyph8 = glyph_map(i_cfg.table_select, code);

    // A code has no glyph when unmapped or beyond the font or the table.
    assign no_glyph = (glyph8 == NG) || (glyph8 >= i_cfg.glyph_count) ||
                      ({1'b0, glyph8} >= 9'(MAX_GLYPHS));

    // Classify the item into one operation.
    always_comb begin
        n_op         = '0;
        n_op.slot    = i_s_axis_tdata[6:0];
        n_op.width   = i_s_axis_tdata[14:7];
        n_op.height  = i_s_axis_tdata[22:15];
        n_op.start_x = i_s_axis_tdata[38:23];
        n_op.start_y = i_s_axis_tdata[54:39];
        n_op.color_a = i_s_axis_tdata[62:55];
        n_op.color_b = i_s_axis_tdata[70:63];
        n_op.glyph   = glyph8[6:0];
        case (i_s_axis_tuser)
            CMD_LOAD: begin
                n_op.kind = ({2'b00, n_op.slot} < 9'(MAX_GLYPHS)) ? OP_LOAD : OP_NOP;
            end
            CMD_START: begin
                n_op.kind = OP_START;
            end
            CMD_CHAR: begin
                if (code == CODE_TILDE) begin
                    n_op.kind = OP_TILDE;
                end else if (code == CODE_NEWLINE || code == CODE_NEWLINE_ALT) begin
                    n_op.kind = OP_NEWLINE;
                end else if (code == CODE_TAB) begin
                    n_op.kind = OP_TAB;
                end else if (no_glyph) begin
                    n_op.kind = OP_SPACE;
                end else begin
                    n_op.kind = OP_GLYPH;
                end
            end
            default: begin
                n_op.kind = OP_NOP;
            end
        endcase
    end

    assign o_s_axis_tready = (r_cnt < (QPW+1)'(QDEPTH));
    assign push            = i_s_axis_tvalid && o_s_axis_tready && (n_op.kind != OP_NOP);
    assign o_op_valid      = (r_cnt != '0);
    assign o_op            = r_q[r_rptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= n_op;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_op_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !i_op_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_op_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/blt_back.sv =====
// Back end: keeps the pen state, runs the tab divider and drives the results.
module blt_back #(
    parameter int MAX_GLYPHS = blt_pkg::MAX_GLYPHS_DEF,
    parameter int TAB_CELLS  = blt_pkg::TAB_CELLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  blt_pkg::t_cfg                   i_cfg,
    input  logic                            i_op_valid,
    input  blt_pkg::t_op                    i_op,
    output logic                            o_op_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata from bit 0: draw_x, draw_y, glyph_index, draw_color, one zero pad bit
    output logic [blt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    import blt_pkg::*;

    localparam int AW     = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CELL_W = $clog2(TAB_CELLS * 255 + 1);
    localparam int DIV_N  = 16;
    localparam int CNT_W  = $clog2(DIV_N);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EMIT = 6'b000100,
        S_DIV  = 6'b001000,
        S_MUL  = 6'b010000,
        S_ADD  = 6'b100000
    } t_state;

    t_state            r_state;
    logic [15:0]       r_pen_x;
    logic [15:0]       r_pen_y;
    logic [15:0]       r_origin_x;
    logic [7:0]        r_base_h;
    logic [7:0]        r_w0;
    logic [CELL_W-1:0] r_cell;
    logic              r_pick;
    logic [7:0]        r_color_a;
    logic [7:0]        r_color_b;
    logic [6:0]        r_glyph;
    logic [7:0]        r_w;
    logic [15:0]       r_draw_x;
    logic              r_neg;
    logic [15:0]       r_quo;
    logic [CELL_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [15:0]       r_prod;
    logic              r_out_valid;
    logic [15:0]       r_out_x;
    logic [15:0]       r_out_y;
    logic [6:0]        r_out_g;
    logic [7:0]        r_out_c;

    logic              ram_we;
    logic [7:0]        slot8;
    logic [7:0]        glyph8;
    logic [7:0]        ram_rdata;
    logic [15:0]       h_ext;
    logic [15:0]       v_ext;
    logic [15:0]       pen_dist;
    logic [15:0]       dist_mag;
    logic [CELL_W:0]   rem_sh;
    logic              rem_ge;
    logic [CELL_W:0]   rem_sub;
    logic [15:0]       quo_n;
    logic [15:0]       cell16;
    logic [CELL_W-1:0] cell_load;
    logic              out_free;
    logic              emit_now;

    // Width table, written by load items and read for each drawn glyph.
    assign ram_we = o_op_pop && (i_op.kind == OP_LOAD);
    assign slot8  = {1'b0, i_op.slot};
    assign glyph8 = {1'b0, i_op.glyph};

    blt_ram #(
        .WIDTH (8),
        .DEPTH (MAX_GLYPHS),
        .AW    (AW)
    ) u_width_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot8[AW-1:0]),
        .i_wdata (i_op.width),
        .i_raddr (glyph8[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_op_pop = (r_state == S_IDLE) && i_op_valid;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign emit_now = (r_state == S_EMIT) && out_free;
    assign h_ext    = {{8{i_cfg.h_spacing[7]}}, i_cfg.h_spacing};
    assign v_ext    = {{8{i_cfg.v_spacing[7]}}, i_cfg.v_spacing};

    // Signed distance from the origin, split into sign and magnitude.
    assign pen_dist = r_pen_x - r_origin_x;
    assign dist_mag = pen_dist[15] ? (16'd0 - pen_dist) : pen_dist;

    // One restoring division step.
    assign rem_sh  = {r_rem, r_quo[15]};
    assign rem_ge  = (rem_sh >= {1'b0, r_cell});
    assign rem_sub = rem_sh - {1'b0, r_cell};

    // Tab stop index plus one, and the cell size for the product.
    assign quo_n  = (r_neg ? (16'd0 - r_quo) : r_quo) + 16'd1;
    assign cell16 = 16'(r_cell);

    assign cell_load = CELL_W'(CELL_W'(TAB_CELLS) * CELL_W'(i_op.width));

    // Operation sequencer and pen state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_origin_x  <= '0;
            r_base_h    <= '0;
            r_w0        <= '0;
            r_cell      <= '0;
            r_pick      <= 1'b0;
            r_color_a   <= '0;
            r_color_b   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Result register: loaded by the emit step, freed when taken.
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_op_valid) begin
                        case (i_op.kind)
                            OP_LOAD: begin
                                if (i_op.slot == '0) begin
                                    r_w0     <= i_op.width;
                                    r_cell   <= cell_load;
                                    r_base_h <= i_op.height;
                                end
                            end
                            OP_START: begin
                                r_pen_x    <= i_op.start_x;
                                r_origin_x <= i_op.start_x;
                                r_pen_y    <= i_op.start_y;
                                r_color_a  <= i_op.color_a;
                                r_color_b  <= i_op.color_b;
                                r_pick     <= 1'b0;
                            end
                            OP_TILDE: begin
                                r_pick <= !r_pick;
                            end
                            OP_NEWLINE: begin
                                r_pen_x <= r_origin_x;
                                r_pen_y <= r_pen_y + v_ext + {8'd0, r_base_h};
                            end
                            OP_SPACE: begin
                                r_pen_x <= r_pen_x + h_ext + {9'd0, r_w0[7:1]};
                            end
                            OP_TAB: begin
                                if (r_cell != '0) begin
                                    r_neg   <= pen_dist[15];
                                    r_quo   <= dist_mag;
                                    r_rem   <= '0;
                                    r_cnt   <= CNT_W'(DIV_N - 1);
                                    r_state <= S_DIV;
                                end
                            end
                            OP_GLYPH: begin
                                r_glyph <= i_op.glyph;
                                r_state <= S_READ;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // Width is back from the table; right-align when asked.
                    r_w <= ram_rdata;
                    if (i_cfg.monospace_align) begin
                        r_draw_x <= r_pen_x + {8'd0, r_w0} - {8'd0, ram_rdata};
                    end else begin
                        r_draw_x <= r_pen_x;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_now) begin
                        r_out_x     <= r_draw_x;
                        r_out_y     <= r_pen_y;
                        r_out_g     <= r_glyph;
                        r_out_c     <= r_pick ? r_color_b : r_color_a;
                        r_pen_x     <= r_draw_x + h_ext + {8'd0, r_w};
                        r_state     <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_rem <= rem_ge ? rem_sub[CELL_W-1:0] : rem_sh[CELL_W-1:0];
                    r_quo <= {r_quo[14:0], rem_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= quo_n * cell16;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_pen_x <= r_origin_x + r_prod;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_c, r_out_g, r_out_y, r_out_x};

`ifndef SYNTHESIS
    // The divider only runs with a nonzero tab cell.
    a_div_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cell != '0))
        else $error("tab divider running with a zero cell");

    // A new result appears only out of the emit step.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !$past(o_m_axis_tvalid)) |-> $past(r_state == S_EMIT))
        else $error("result raised outside the emit step");

    // A start item always selects the first color.
    a_start_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op_pop && i_op.kind == OP_START) |=> !r_pick)
        else $error("color select not cleared by a start item");

    // A glyph always runs through the table read and the emit step.
    a_glyph_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op_pop && i_op.kind == OP_GLYPH) |=> (r_state == S_READ) ##1 (r_state == S_EMIT))
        else $error("glyph sequence broken");
`endif

endmodule

// ===== sv/bitmap_text_layout.sv =====
// Top level of the bitmap text layout block: configuration registers and wiring.
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         tvalid/tready             tuser command, tdata operands
// m_axis    out        tvalid/tready             draw position, glyph, color
// cfg       in         write enable, no wait     index and 8-bit write data
//
// Each item is done in the issue step alone, but for a drawn glyph (issue,
// registered width table read, emit, which waits for a free result register)
// and a tab with a nonzero cell (issue, the 16 bit-serial tab divider steps,
// multiply, add). A two-entry queue separates accept from execution; a held
// result stalls only the back end until the queue fills. Reset is synchronous
// and needs no clearing pass; the width table holds garbage until loaded.
module bitmap_text_layout #(
    parameter int MAX_GLYPHS = blt_pkg::MAX_GLYPHS_DEF,
    parameter int TAB_CELLS  = blt_pkg::TAB_CELLS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata from bit 0: glyph_slot, glyph_width, glyph_height, start_x, start_y,
    // color_a, color_b, char_code, one zero pad bit
    input  logic [blt_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // tuser: command
    input  logic [blt_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata from bit 0: draw_x, draw_y, glyph_index, draw_color, one zero pad bit
    output logic [blt_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [blt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [blt_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    import blt_pkg::*;

    t_cfg r_cfg;
    logic op_valid;
    t_op  op;
    logic op_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GLYPH_COUNT:     r_cfg.glyph_count     <= i_cfg_wdata;
                CFG_TABLE_SELECT:    r_cfg.table_select    <= i_cfg_wdata[0];
                CFG_MONOSPACE_ALIGN: r_cfg.monospace_align <= i_cfg_wdata[0];
                CFG_H_SPACING:       r_cfg.h_spacing       <= i_cfg_wdata;
                CFG_V_SPACING:       r_cfg.v_spacing       <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    blt_front #(
        .MAX_GLYPHS (MAX_GLYPHS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_op_valid      (op_valid),
        .o_op            (op),
        .i_op_pop        (op_pop)
    );

    blt_back #(
        .MAX_GLYPHS (MAX_GLYPHS),
        .TAB_CELLS  (TAB_CELLS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_op_valid      (op_valid),
        .i_op            (op),
        .o_op_pop        (op_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
